[src/gfa_pkg.sv]
// package with shared types, constants and helper functions for the givens frame alignment block
package gfa_pkg;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic [24:0]        SNAP_RESET = 25'd17;
    localparam int                 SQRT_BITS = 33;

    typedef logic signed [31:0] t_word;

    // rounding to nearest with ties away from zero, dropping 30 bits, then saturating
    function automatic t_word round30(input logic signed [65:0] acc);
        logic        neg;
        logic [65:0] mag;
        logic [65:0] rnd;
        logic signed [66:0] res;
        neg = acc[65];
        mag = neg ? 66'(-acc) : 66'(acc);
        rnd = (mag + 66'(1 << 29)) >> 30;
        res = neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
        if (res > 67'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (res < -67'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return res[31:0];
        end
    endfunction

    function automatic t_word snap(input t_word t, input logic [24:0] thr);
        logic [32:0] mag;
        mag = t[31] ? 33'(-$signed({t[31], t})) : {1'b0, t};
        return (mag < {8'd0, thr}) ? 32'sd0 : t;
    endfunction

endpackage

[src/gfa_cs_unit.sv]
// pipelined norm and cosine/sine unit for one plane rotation
module gfa_cs_unit
    import gfa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_p,
    input  t_word i_q,
    output t_word o_c,
    output t_word o_s,
    output logic  o_degen
);
    // stage counts: 33 root steps, then 62 divide steps for both quotients
    localparam int RS = SQRT_BITS;
    localparam int DS = 62;

    logic [31:0] r_pm [RS+1];
    logic [31:0] r_qm [RS+1];
    logic        r_pn [RS+1];
    logic        r_qn [RS+1];
    logic [65:0] r_rem [RS+1];
    logic [32:0] r_root [RS+1];
    logic [65:0] r_val [RS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pn[0]   <= i_p[31];
            r_qn[0]   <= i_q[31];
            r_pm[0]   <= i_p[31] ? 32'(-i_p) : 32'(i_p);
            r_qm[0]   <= i_q[31] ? 32'(-i_q) : 32'(i_q);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_val[0]  <= 66'(({32'd0, (i_p[31] ? 32'(-i_p) : 32'(i_p))}
                             * {32'd0, (i_p[31] ? 32'(-i_p) : 32'(i_p))})
                           + ({32'd0, (i_q[31] ? 32'(-i_q) : 32'(i_q))}
                             * {32'd0, (i_q[31] ? 32'(-i_q) : 32'(i_q))}));
        end
    end

    // restoring square root, two radicand bits a stage
    for (genvar k = 0; k < RS; k++) begin : g_root
        logic [65:0] n_rem;
        logic [65:0] n_trial;
        always_comb begin
            n_rem   = {r_rem[k][63:0], r_val[k][65:64]};
            n_trial = {31'd0, r_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pm[k+1]  <= r_pm[k];
                r_qm[k+1]  <= r_qm[k];
                r_pn[k+1]  <= r_pn[k];
                r_qn[k+1]  <= r_qn[k];
                r_val[k+1] <= {r_val[k][63:0], 2'b00};
                if (n_rem >= n_trial) begin
                    r_rem[k+1]  <= n_rem - n_trial;
                    r_root[k+1] <= {r_root[k][31:0], 1'b1};
                end else begin
                    r_rem[k+1]  <= n_rem;
                    r_root[k+1] <= {r_root[k][31:0], 1'b0};
                end
            end
        end
    end

    // long division of (m<<30 + n/2) by n, one quotient bit a stage
    logic [32:0] r_n   [DS+1];
    logic [63:0] r_qq  [DS+1];
    logic [63:0] r_qp  [DS+1];
    logic [33:0] r_rq  [DS+1];
    logic [33:0] r_rp  [DS+1];
    logic        r_sq  [DS+1];
    logic        r_sp  [DS+1];
    // dividends: m*2^30 + n/2, 62 bits
    logic [61:0] r_dq [DS+1];
    logic [61:0] r_dp [DS+1];

    always_comb begin
        r_n[0]  = r_root[RS];
        r_qq[0] = '0;
        r_qp[0] = '0;
        r_rq[0] = '0;
        r_rp[0] = '0;
        r_sq[0] = r_qn[RS];
        r_sp[0] = r_pn[RS];
        r_dq[0] = {r_qm[RS], 30'd0} + 62'(r_root[RS] >> 1);
        r_dp[0] = {r_pm[RS], 30'd0} + 62'(r_root[RS] >> 1);
    end

    for (genvar k = 0; k < DS; k++) begin : g_div
        logic [33:0] n_aq;
        logic [33:0] n_ap;
        always_comb begin
            n_aq = {r_rq[k][32:0], r_dq[k][61]};
            n_ap = {r_rp[k][32:0], r_dp[k][61]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]  <= r_n[k];
                r_sq[k+1] <= r_sq[k];
                r_sp[k+1] <= r_sp[k];
                r_dq[k+1] <= {r_dq[k][60:0], 1'b0};
                r_dp[k+1] <= {r_dp[k][60:0], 1'b0};
                if (n_aq >= {1'b0, r_n[k]}) begin
                    r_rq[k+1] <= n_aq - {1'b0, r_n[k]};
                    r_qq[k+1] <= {r_qq[k][62:0], 1'b1};
                end else begin
                    r_rq[k+1] <= n_aq;
                    r_qq[k+1] <= {r_qq[k][62:0], 1'b0};
                end
                if (n_ap >= {1'b0, r_n[k]}) begin
                    r_rp[k+1] <= n_ap - {1'b0, r_n[k]};
                    r_qp[k+1] <= {r_qp[k][62:0], 1'b1};
                end else begin
                    r_rp[k+1] <= n_ap;
                    r_qp[k+1] <= {r_qp[k][62:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        o_degen = (r_n[DS] == '0);
        if (o_degen) begin
            o_c = ONE_Q30;
            o_s = '0;
        end else begin
            o_c = r_sq[DS] ? -$signed(r_qq[DS][31:0]) : $signed(r_qq[DS][31:0]);
            o_s = r_sp[DS] ? -$signed(r_qp[DS][31:0]) : $signed(r_qp[DS][31:0]);
        end
    end
endmodule

[src/givens_frame_alignment_3d_top.sv]
// top level of the givens frame alignment block
// the result port gives one row per cycle while not stalled; a finished item is taken
// while no rows are pending or as the last row of the previous item leaves
// the whole datapath is one stall-gated pipeline; valid bits travel with the data
// reset (synchronous, active low) clears valid bits and loads snap threshold 17
// a stall on the result side freezes every stage, nothing is lost or repeated
module givens_frame_alignment_3d_top
    import gfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [24:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_word       i_e_x,
    input  t_word       i_e_y,
    input  t_word       i_e_z,
    input  t_word       i_b_x,
    input  t_word       i_b_y,
    input  t_word       i_b_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_row_index,
    output t_word       o_entry_first,
    output t_word       o_entry_second,
    output t_word       o_entry_third,
    output t_word       o_rotated_e,
    output t_word       o_rotated_b,
    output logic        o_degenerate,
    output logic        o_last_row
);
    localparam int CSL = 33 + 62 + 1;   // registers along one cos/sin unit (incl. input reg)
    localparam int ND  = 3 * CSL + 12;  // depth of the delay line for the item

    logic [24:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= SNAP_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // the pipeline advances when the row serialiser can take an item
    // (not while rows 0 and 1 are pending, nor while a last row is stalled)
    logic w_adv;
    logic [1:0] r_row;
    logic       r_hold;
    logic       r_ov;
    assign w_adv   = !r_hold && !(r_ov && i_stall);
    assign o_stall = !w_adv;

    // item delay line: original vectors plus valid, stage 0 is the input
    t_word r_e [ND+1][3];
    t_word r_b [ND+1][3];
    logic  r_v [ND+1];
    always_comb begin
        r_e[0][0] = i_e_x; r_e[0][1] = i_e_y; r_e[0][2] = i_e_z;
        r_b[0][0] = i_b_x; r_b[0][1] = i_b_y; r_b[0][2] = i_b_z;
        r_v[0]    = i_valid;
    end
    for (genvar k = 0; k < ND; k++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_v[k+1] <= r_v[k];
            end
            if (w_adv) begin
                r_e[k+1] <= r_e[k];
                r_b[k+1] <= r_b[k];
            end
        end
    end

    // rotation 1 from (e_x, e_y)
    t_word c1, s1, c2, s2, c3, s3;
    logic  d1, d2, d3;
    gfa_cs_unit u_cs1 (.i_clk, .i_en(w_adv), .i_p(i_e_x), .i_q(i_e_y),
                       .o_c(c1), .o_s(s1), .o_degen(d1));

    // stage A (at CSL): e1 = R1 e, b1 = R1 b; registered products, then sums
    localparam int A = CSL;
    t_word r_c1a, r_s1a; logic r_d1a;
    t_word r_c1, r_s1; logic r_d1;
    t_word r_e1y, r_e1z, r_b1x, r_b1y, r_b1z;
    logic signed [63:0] r_pa [6];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pa[0] <= c1 * r_e[A][1];   // e1y: s*ex + c*ey
            r_pa[1] <= s1 * r_e[A][0];
            r_pa[2] <= c1 * r_b[A][0];   // b1x: c*bx - s*by
            r_pa[3] <= s1 * r_b[A][1];
            r_pa[4] <= s1 * r_b[A][0];   // b1y: s*bx + c*by
            r_pa[5] <= c1 * r_b[A][1];
            r_c1a <= c1; r_s1a <= s1; r_d1a <= d1;
        end
    end
    // sums, with the z components and R1 kept in step
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e1y <= snap(round30(66'(r_pa[1]) + 66'(r_pa[0])), r_thr);
            r_b1x <= snap(round30(66'(r_pa[2]) - 66'(r_pa[3])), r_thr);
            r_b1y <= snap(round30(66'(r_pa[4]) + 66'(r_pa[5])), r_thr);
            r_e1z <= snap(r_e[A+1][2], r_thr);
            r_b1z <= snap(r_b[A+1][2], r_thr);
            r_c1 <= r_c1a; r_s1 <= r_s1a; r_d1 <= r_d1a;
        end
    end

    // rotation 2 from (e1y, e1z), entering at A+2
    gfa_cs_unit u_cs2 (.i_clk, .i_en(w_adv), .i_p(r_e1y), .i_q(r_e1z),
                       .o_c(c2), .o_s(s2), .o_degen(d2));

    // carry R1 and b1 to B = A+2+CSL
    localparam int B = A + 2 + CSL;
    t_word r_k1c [CSL+1], r_k1s [CSL+1], r_kbx [CSL+1], r_kby [CSL+1], r_kbz [CSL+1];
    logic  r_k1d [CSL+1];
    always_comb begin
        r_k1c[0] = r_c1; r_k1s[0] = r_s1; r_k1d[0] = r_d1;
        r_kbx[0] = r_b1x; r_kby[0] = r_b1y; r_kbz[0] = r_b1z;
    end
    for (genvar k = 0; k < CSL; k++) begin : g_k1
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_k1c[k+1] <= r_k1c[k]; r_k1s[k+1] <= r_k1s[k]; r_k1d[k+1] <= r_k1d[k];
                r_kbx[k+1] <= r_kbx[k]; r_kby[k+1] <= r_kby[k]; r_kbz[k+1] <= r_kbz[k];
            end
        end
    end

    // stage B: b2 = R2 b1 -> b2x = b1x, b2y = c*b1y - s*b1z
    t_word r_c2, r_s2; logic r_d2;
    t_word r_b2x, r_b2y;
    logic signed [63:0] r_pb [2];
    t_word r_c1b, r_s1b; logic r_d1b;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pb[0] <= c2 * r_kby[CSL];
            r_pb[1] <= s2 * r_kbz[CSL];
            r_c2 <= c2; r_s2 <= s2; r_d2 <= d2;
            r_b2x <= snap(r_kbx[CSL], r_thr);
            r_c1b <= r_k1c[CSL]; r_s1b <= r_k1s[CSL]; r_d1b <= r_k1d[CSL];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b2y <= snap(round30(66'(r_pb[0]) - 66'(r_pb[1])), r_thr);
        end
    end

    // rotation 3 from (b2x, b2y), entering at B+2 (b2x needs one more register)
    t_word r_b2xd;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b2xd <= r_b2x;
        end
    end
    gfa_cs_unit u_cs3 (.i_clk, .i_en(w_adv), .i_p(r_b2xd), .i_q(r_b2y),
                       .o_c(c3), .o_s(s3), .o_degen(d3));

    // carry R1, R2 to C = B+2+CSL
    localparam int C = B + 2 + CSL;
    t_word r_kc [CSL+2][4];
    logic  r_kd [CSL+2];
    always_comb begin
        r_kc[0][0] = r_c1b; r_kc[0][1] = r_s1b; r_kc[0][2] = r_c2; r_kc[0][3] = r_s2;
        r_kd[0] = r_d1b | r_d2;
    end
    for (genvar k = 0; k < CSL + 1; k++) begin : g_k2
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_kc[k+1] <= r_kc[k];
                r_kd[k+1] <= r_kd[k];
            end
        end
    end
    // r_kc[CSL+1] lines up with c3 (r_c2 is itself a register stage past c2)
    t_word w1c, w1s, w2c, w2s;
    assign w1c = r_kc[CSL+1][0]; assign w1s = r_kc[CSL+1][1];
    assign w2c = r_kc[CSL+1][2]; assign w2s = r_kc[CSL+1][3];

    // matrix chain: T = R2^T R3 (3x3), U = T R2, R = U R1; products then sums
    // R2^T = [[1,0,0],[0,c2,s2],[0,-s2,c2]], R3 = [[c3,-s3,0],[s3,c3,0],[0,0,1]]
    // T = [[c3,-s3,0],[c2 s3, c2 c3, s2],[-s2 s3, -s2 c3, c2]]
    t_word r_t [3][3];
    logic signed [63:0] r_tp [4];
    t_word r_m1 [4]; t_word r_m3 [2]; logic r_md;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tp[0] <= w2c * s3; r_tp[1] <= w2c * c3;
            r_tp[2] <= w2s * s3; r_tp[3] <= w2s * c3;
            r_m1[0] <= w1c; r_m1[1] <= w1s; r_m1[2] <= w2c; r_m1[3] <= w2s;
            r_m3[0] <= c3; r_m3[1] <= s3;
            r_md <= r_kd[CSL+1] | d3;
        end
    end
    t_word r_m1b [4]; logic r_mdb;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t[0][0] <= r_m3[0]; r_t[0][1] <= -r_m3[1]; r_t[0][2] <= '0;
            r_t[1][0] <= round30(66'(r_tp[0])); r_t[1][1] <= round30(66'(r_tp[1]));
            r_t[1][2] <= r_m1[3];
            r_t[2][0] <= round30(-66'(r_tp[2])); r_t[2][1] <= round30(-66'(r_tp[3]));
            r_t[2][2] <= r_m1[2];
            r_m1b <= r_m1; r_mdb <= r_md;
        end
    end
    // U = T R2: col0 = T col0; col1 = c T1 + s T2; col2 = -s T1 + c T2
    logic signed [63:0] r_up [3][4];
    t_word r_u0 [3]; t_word r_m1c [2]; logic r_mdc;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_up[i][0] <= r_t[i][1] * r_m1b[2];
                r_up[i][1] <= r_t[i][2] * r_m1b[3];
                r_up[i][2] <= r_t[i][1] * r_m1b[3];
                r_up[i][3] <= r_t[i][2] * r_m1b[2];
                r_u0[i] <= r_t[i][0];
            end
            r_m1c[0] <= r_m1b[0]; r_m1c[1] <= r_m1b[1]; r_mdc <= r_mdb;
        end
    end
    t_word r_u [3][3]; t_word r_m1d [2]; logic r_mdd;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i][0] <= r_u0[i];
                r_u[i][1] <= round30(66'(r_up[i][0]) + 66'(r_up[i][1]));
                r_u[i][2] <= round30(66'(r_up[i][3]) - 66'(r_up[i][2]));
            end
            r_m1d <= r_m1c; r_mdd <= r_mdc;
        end
    end
    // R = U R1: col0 = c U0 + s U1; col1 = -s U0 + c U1; col2 = U2
    logic signed [63:0] r_rp [3][4];
    t_word r_u2 [3]; logic r_mde;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_rp[i][0] <= r_u[i][0] * r_m1d[0];
                r_rp[i][1] <= r_u[i][1] * r_m1d[1];
                r_rp[i][2] <= r_u[i][0] * r_m1d[1];
                r_rp[i][3] <= r_u[i][1] * r_m1d[0];
                r_u2[i] <= r_u[i][2];
            end
            r_mde <= r_mdd;
        end
    end
    t_word r_r [3][3]; logic r_mdf;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_r[i][0] <= round30(66'(r_rp[i][0]) + 66'(r_rp[i][1]));
                r_r[i][1] <= round30(66'(r_rp[i][3]) - 66'(r_rp[i][2]));
                r_r[i][2] <= r_u2[i];
            end
            r_mdf <= r_mde;
        end
    end
    // R e and R b: nine products each, registered, then summed
    localparam int D = C + 6;
    logic signed [63:0] r_vp [2][3][3];
    t_word r_rr [3][3]; logic r_mdg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_vp[0][i][j] <= r_r[i][j] * r_e[D][j];
                    r_vp[1][i][j] <= r_r[i][j] * r_b[D][j];
                end
            end
            r_rr <= r_r; r_mdg <= r_mdf;
        end
    end
    t_word r_oe [3], r_ob [3]; t_word r_orr [3][3]; logic r_odg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_oe[i] <= snap(round30(66'(r_vp[0][i][0]) + 66'(r_vp[0][i][1])
                                        + 66'(r_vp[0][i][2])), r_thr);
                r_ob[i] <= snap(round30(66'(r_vp[1][i][0]) + 66'(r_vp[1][i][1])
                                        + 66'(r_vp[1][i][2])), r_thr);
            end
            r_orr <= r_rr; r_odg <= r_mdg;
        end
    end
    localparam int F = D + 2;

    // row serialiser: takes a finished item and emits three rows
    t_word r_se [3], r_sb [3]; t_word r_sr [3][3]; logic r_sd;
    logic  w_take;
    assign w_take = r_v[F] && w_adv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_row  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (w_take) begin
                r_hold <= 1'b1;
                r_row  <= '0;
                r_ov   <= 1'b1;
            end else if (r_ov && !i_stall) begin
                if (r_row == 2'd2) begin
                    r_ov <= 1'b0;
                    r_hold <= 1'b0;
                end else begin
                    r_row <= r_row + 2'd1;
                    if (r_row == 2'd1) begin
                        r_hold <= 1'b0;
                    end
                end
            end
        end
    end
    // an item may be taken as the last row leaves
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_se <= r_oe; r_sb <= r_ob; r_sr <= r_orr; r_sd <= r_odg;
        end
    end

    assign o_valid        = r_ov;
    assign o_row_index    = r_row;
    assign o_entry_first  = r_sr[r_row][0];
    assign o_entry_second = r_sr[r_row][1];
    assign o_entry_third  = r_sr[r_row][2];
    assign o_rotated_e    = r_se[r_row];
    assign o_rotated_b    = r_sb[r_row];
    assign o_degenerate   = r_sd;
    assign o_last_row     = (r_row == 2'd2);
endmodule

[src/gfa_checker.sv]
// port-level checker for the givens frame alignment block, with its bind
module gfa_checker
    import gfa_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_row_index,
    input logic        o_last_row,
    input logic        o_degenerate,
    input t_word       o_rotated_e
);
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_row_index != 2'd3) else $error("bad row");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == 2'd2))) else $error("last row");
    a_next_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_row_index == 2'd0) |=> o_valid && o_row_index == 2'd1)
        else $error("row order");
    a_degen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_row_index != 2'd2) |=> $stable(o_degenerate))
        else $error("flag changed");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_rotated_e)) else $error("stall");
endmodule

bind givens_frame_alignment_3d_top gfa_checker u_gfa_checker (.*);
